>>> design/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants for the HSV to RGB conversion pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Hue geometry in whole degrees
  localparam logic [15:0] HUE_TURN   = 16'd360;
  localparam logic [8:0]  HUE_TURN_9 = 9'd360;
  localparam logic [8:0]  DEG_60     = 9'd60;
  localparam logic [8:0]  DEG_120    = 9'd120;
  localparam logic [8:0]  DEG_180    = 9'd180;
  localparam logic [8:0]  DEG_240    = 9'd240;
  localparam logic [8:0]  DEG_300    = 9'd300;

  // Reciprocal of 360: floor(2^24 / 360); quotient estimate is exact or one low
  localparam logic [15:0] RECIP_360       = 16'd46603;
  localparam int          RECIP_360_SHIFT = 24;

  // Reciprocal of 60: ceil(2^20 / 60); exact for dividends below 23831
  localparam logic [14:0] RECIP_60        = 15'd17477;
  localparam int          RECIP_60_SHIFT  = 20;

  // Rounding terms
  localparam logic [15:0] HALF_255 = 16'd127;
  localparam logic [13:0] HALF_60  = 14'd30;

  // 60-degree sector of the folded hue
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // Word passed from the hue fold front end to the channel mix back end
  typedef struct packed {
    logic [8:0] hue;     // folded hue, 0..359
    logic [7:0] chroma;  // rounded value * saturation / 255
    logic [7:0] level;   // HSV value
  } fold_t;

endpackage

>>> design/hsv2rgb_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_fold
// Front end, three stages: hue magnitude and V*S product, mod-360 quotient
// estimate and chroma rounding, remainder with a single correction.
// ----------------------------------------------------------------------------
module hsv2rgb_fold
  import hsv2rgb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_hue_degrees,
  input  logic        [7:0]  in_saturation,
  input  logic        [7:0]  in_brightness,
  output logic               out_valid,
  input  logic               out_ready,
  output fold_t              out_word
);

  logic        v1_r, v2_r, v3_r;
  logic        en1, en2, en3;

  logic [15:0] mag1_r, mag1_nxt;
  logic [15:0] vs1_r, vs1_nxt;
  logic [7:0]  lvl1_r;

  logic [15:0] mag2_r;
  logic [6:0]  q2_r, q2_nxt;
  logic [7:0]  c2_r, c2_nxt;
  logic [7:0]  lvl2_r;

  fold_t       w3_r, w3_nxt;

  logic [31:0] qprod;
  logic [15:0] crnd;
  logic [15:0] csum;
  logic [15:0] qx;
  logic [15:0] rem;

  // Advance a stage when it is empty or the next one advances
  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Stage 1: magnitude of the signed hue, value times saturation
  always_comb begin
    if (in_hue_degrees[15]) begin
      mag1_nxt = 16'(~in_hue_degrees) + 16'd1;
    end else begin
      mag1_nxt = 16'(in_hue_degrees);
    end
    vs1_nxt = 16'(in_saturation) * 16'(in_brightness);
  end

  // Stage 2: quotient estimate by 360, chroma = (vs + 127) / 255
  always_comb begin
    qprod  = 32'(mag1_r) * 32'(RECIP_360);
    q2_nxt = qprod[RECIP_360_SHIFT +: 7];
    crnd   = vs1_r + HALF_255;
    csum   = crnd + (crnd >> 8) + 16'd1;
    c2_nxt = csum[15:8];
  end

  // Stage 3: remainder, subtract 360 once more if the estimate was low
  always_comb begin
    qx  = 16'(q2_r) * HUE_TURN;
    rem = mag2_r - qx;
    if (rem >= HUE_TURN) begin
      w3_nxt.hue = 9'(rem) - HUE_TURN_9;
    end else begin
      w3_nxt.hue = 9'(rem);
    end
    w3_nxt.chroma = c2_r;
    w3_nxt.level  = lvl2_r;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Payload registers, loaded when their stage advances
  always_ff @(posedge clk) begin
    if (en1) begin
      mag1_r <= mag1_nxt;
      vs1_r  <= vs1_nxt;
      lvl1_r <= in_brightness;
    end
    if (en2) begin
      mag2_r <= mag1_r;
      q2_r   <= q2_nxt;
      c2_r   <= c2_nxt;
      lvl2_r <= lvl1_r;
    end
    if (en3) begin
      w3_r <= w3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_word  = w3_r;

endmodule

>>> design/hsv2rgb_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_mix
// Back end, three stages: sector and C*t, rounded division by 60 through a
// reciprocal product, channel placement plus offset.
// ----------------------------------------------------------------------------
module hsv2rgb_mix
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  fold_t      in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red_level,
  output logic [7:0] out_green_level,
  output logic [7:0] out_blue_level
);

  logic        v4_r, v5_r, v6_r;
  logic        en4, en5, en6;

  sector_t     sec4_r, sec4_nxt, sec5_r;
  logic [13:0] ct4_r, ct4_nxt;
  logic [7:0]  c4_r, c5_r;
  logic [7:0]  m4_r, m4_nxt, m5_r;

  logic [27:0] p5_r, p5_nxt;

  logic [7:0]  red6_r, red6_nxt;
  logic [7:0]  grn6_r, grn6_nxt;
  logic [7:0]  blu6_r, blu6_nxt;

  logic [6:0]  r120;
  logic [5:0]  span;
  logic [5:0]  tw;
  logic [13:0] xr;
  logic [7:0]  xv;
  logic [7:0]  cm;

  // Advance a stage when it is empty or the next one advances
  assign en6      = !v6_r || out_ready;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign in_ready = en4;

  // Stage 4: sector, triangle weight t, C*t and offset
  always_comb begin
    priority if (in_word.hue >= DEG_300) sec4_nxt = SEC_MAG_RED;
    else if (in_word.hue >= DEG_240)     sec4_nxt = SEC_BLU_MAG;
    else if (in_word.hue >= DEG_180)     sec4_nxt = SEC_CYN_BLU;
    else if (in_word.hue >= DEG_120)     sec4_nxt = SEC_GRN_CYN;
    else if (in_word.hue >= DEG_60)      sec4_nxt = SEC_YEL_GRN;
    else                                 sec4_nxt = SEC_RED_YEL;

    priority if (in_word.hue >= DEG_240) r120 = 7'(in_word.hue - DEG_240);
    else if (in_word.hue >= DEG_120)     r120 = 7'(in_word.hue - DEG_120);
    else                                 r120 = 7'(in_word.hue);

    if (r120 >= 7'(DEG_60)) begin
      span = 6'(r120 - 7'(DEG_60));
    end else begin
      span = 6'(7'(DEG_60) - r120);
    end
    tw      = 6'(DEG_60) - span;
    ct4_nxt = 14'(in_word.chroma) * 14'(tw);
    m4_nxt  = in_word.level - in_word.chroma;
  end

  // Stage 5: (C*t + 30) times the reciprocal of 60
  always_comb begin
    xr     = ct4_r + HALF_60;
    p5_nxt = 28'(xr) * 28'(RECIP_60);
  end

  // Stage 6: place chroma and X by sector, add the offset
  always_comb begin
    xv  = p5_r[RECIP_60_SHIFT +: 8];
    cm  = c5_r + m5_r;
    unique case (sec5_r)
      SEC_RED_YEL: begin red6_nxt = cm;        grn6_nxt = xv + m5_r; blu6_nxt = m5_r;      end
      SEC_YEL_GRN: begin red6_nxt = xv + m5_r; grn6_nxt = cm;        blu6_nxt = m5_r;      end
      SEC_GRN_CYN: begin red6_nxt = m5_r;      grn6_nxt = cm;        blu6_nxt = xv + m5_r; end
      SEC_CYN_BLU: begin red6_nxt = m5_r;      grn6_nxt = xv + m5_r; blu6_nxt = cm;        end
      SEC_BLU_MAG: begin red6_nxt = xv + m5_r; grn6_nxt = m5_r;      blu6_nxt = cm;        end
      default:     begin red6_nxt = cm;        grn6_nxt = m5_r;      blu6_nxt = xv + m5_r; end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en4) v4_r <= in_valid;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // Payload registers, loaded when their stage advances
  always_ff @(posedge clk) begin
    if (en4) begin
      sec4_r <= sec4_nxt;
      ct4_r  <= ct4_nxt;
      c4_r   <= in_word.chroma;
      m4_r   <= m4_nxt;
    end
    if (en5) begin
      sec5_r <= sec4_r;
      p5_r   <= p5_nxt;
      c5_r   <= c4_r;
      m5_r   <= m4_r;
    end
    if (en6) begin
      red6_r <= red6_nxt;
      grn6_r <= grn6_nxt;
      blu6_r <= blu6_nxt;
    end
  end

  assign out_valid       = v6_r;
  assign out_red_level   = red6_r;
  assign out_green_level = grn6_r;
  assign out_blue_level  = blu6_r;

endmodule

>>> design/hsv_to_rgb_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert
// HSV to RGB color conversion, six-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one pixel word: a signed hue
//   in whole degrees, 8-bit saturation and 8-bit value. The hue folds as
//   |hue rem 360|, so -30 acts as 30. Output channel (out_valid / out_ready)
//   carries 8-bit red, green and blue.
//   Path: an accepted word moves through stage registers 1 to 6 in order,
//   and out_valid rises when it reaches stage 6.
//   Throughput: one word per cycle while out_ready is high; each of the six
//   stages holds one word and hands it on as the next one advances (the
//   two reciprocal products, mod-360 and divide-by-60, set the stage cut).
//   Stall: when out_ready is low the last stage holds its word; empty
//   stages upstream keep filling, so up to six words sit in flight before
//   in_ready drops. No word is lost or repeated.
//   Reset: rst_n low at a clock edge empties the pipe; in_ready is high and
//   out_valid low right after.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert
  import hsv2rgb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_hue_degrees,
  input  logic        [7:0]  in_saturation,
  input  logic        [7:0]  in_brightness,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [7:0]  out_red_level,
  output logic        [7:0]  out_green_level,
  output logic        [7:0]  out_blue_level
);

  logic  mid_valid;
  logic  mid_ready;
  fold_t mid_word;
  logic [2:0] occ_r, occ_nxt;

  // Hue fold and chroma
  hsv2rgb_fold u_fold (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_hue_degrees (in_hue_degrees),
    .in_saturation  (in_saturation),
    .in_brightness  (in_brightness),
    .out_valid      (mid_valid),
    .out_ready      (mid_ready),
    .out_word       (mid_word)
  );

  // Sector placement and channel mix
  hsv2rgb_mix u_mix (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (mid_valid),
    .in_ready        (mid_ready),
    .in_word         (mid_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level)
  );

  // Track words in flight for the checks below
  always_comb begin
    occ_nxt = occ_r;
    if (in_valid && in_ready && !(out_valid && out_ready)) begin
      occ_nxt = occ_r + 3'd1;
    end else if (!(in_valid && in_ready) && out_valid && out_ready) begin
      occ_nxt = occ_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 3'd0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // Input backpressure only when the whole pipe is full behind a stall
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && occ_r == 3'd6))
    else $error("in_ready low without a full, stalled pipe");

  // Never more than six words in flight
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= 3'd6)
    else $error("pipe holds more than six words");

  // An empty pipe shows no result
  a_empty_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == 3'd0) |-> !out_valid)
    else $error("result word shown with empty pipe");

  // A full pipe always has a word at the output
  a_full_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == 3'd6) |-> out_valid)
    else $error("full pipe without a result word");

endmodule

>>> tb/hsv_to_rgb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_checker
// Watches both channels of hsv_to_rgb_convert, predicts the color of every
// accepted pixel word and compares each delivered word against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module hsv_to_rgb_checker
  import hsv2rgb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_hue_degrees,
  input  logic        [7:0]  in_saturation,
  input  logic        [7:0]  in_brightness,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic        [7:0]  out_red_level,
  input  logic        [7:0]  out_green_level,
  input  logic        [7:0]  out_blue_level,
  output int                 fail_count,
  output int                 colors_pending,
  output int                 colors_checked
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  rgb_t expected_colors[$];

  // Integer HSV to RGB: fold hue to |hue rem 360|, place chroma and the
  // secondary term by sector, then lift every channel by value - chroma
  function automatic rgb_t hsv_color(logic signed [15:0] hue, logic [7:0] sat,
                                     logic [7:0] val);
    logic [15:0] mag;
    logic [8:0]  folded;
    logic [15:0] chroma_wide;
    logic [7:0]  chroma;
    logic [6:0]  rem120;
    logic [6:0]  span;
    logic [6:0]  ramp;
    logic [13:0] second;
    logic [7:0]  base;
    sector_t     sector;
    rgb_t        rgb;
    mag         = hue[15] ? (~hue + 16'd1) : hue;
    folded      = 9'(mag % 16'd360);
    chroma_wide = (16'(val) * 16'(sat) + 16'd127) / 16'd255;
    chroma      = chroma_wide[7:0];
    rem120      = 7'(folded % 9'd120);
    span        = (rem120 >= 7'd60) ? (rem120 - 7'd60) : (7'd60 - rem120);
    ramp        = 7'd60 - span;
    second      = (14'(chroma) * 14'(ramp) + 14'd30) / 14'd60;
    base        = val - chroma;
    sector      = sector_t'(3'(folded / 9'd60));
    case (sector)
      SEC_RED_YEL: rgb = '{chroma + base, second[7:0] + base, base};
      SEC_YEL_GRN: rgb = '{second[7:0] + base, chroma + base, base};
      SEC_GRN_CYN: rgb = '{base, chroma + base, second[7:0] + base};
      SEC_CYN_BLU: rgb = '{base, second[7:0] + base, chroma + base};
      SEC_BLU_MAG: rgb = '{second[7:0] + base, base, chroma + base};
      default:     rgb = '{chroma + base, base, second[7:0] + base};
    endcase
    return rgb;
  endfunction

  initial begin
    fail_count     = 0;
    colors_pending = 0;
    colors_checked = 0;
  end

  // Predict on input accept, compare on output accept
  always @(posedge clk) begin
    rgb_t want;
    rgb_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_colors.push_back(hsv_color(in_hue_degrees, in_saturation, in_brightness));
      end
      if (out_valid && out_ready) begin
        got = '{out_red_level, out_green_level, out_blue_level};
        if (expected_colors.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10) begin
            $display("checker: unexpected output word r=%0d g=%0d b=%0d",
                     got.red, got.green, got.blue);
          end
        end else begin
          want = expected_colors.pop_front();
          colors_checked = colors_checked + 1;
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10) begin
              $display("checker: mismatch at word %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       colors_checked, want.red, want.green, want.blue,
                       got.red, got.green, got.blue);
            end
          end
        end
      end
      colors_pending = expected_colors.size();
    end
  end

endmodule

>>> tb/tb_hsv_to_rgb_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_convert
// Drives pixel words into hsv_to_rgb_convert with random gaps and output
// stalls: directed hues at sector edges, fold corners and level extremes,
// then random words. The checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_convert;

  localparam int RANDOM_WORDS = 750;
  localparam int CYCLE_LIMIT  = 400000;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_hue_degrees  = '0;
  logic        [7:0]  in_saturation   = '0;
  logic        [7:0]  in_brightness   = '0;
  logic               out_valid;
  logic               out_ready       = 1'b0;
  logic        [7:0]  out_red_level;
  logic        [7:0]  out_green_level;
  logic        [7:0]  out_blue_level;

  int fail_count;
  int colors_pending;
  int colors_checked;
  int words_sent   = 0;
  int cycle_count  = 0;
  int stall_left   = 0;
  bit steady       = 1'b0;

  hsv_to_rgb_convert i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_hue_degrees  (in_hue_degrees),
    .in_saturation   (in_saturation),
    .in_brightness   (in_brightness),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level)
  );

  hsv_to_rgb_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_hue_degrees  (in_hue_degrees),
    .in_saturation   (in_saturation),
    .in_brightness   (in_brightness),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .fail_count      (fail_count),
    .colors_pending  (colors_pending),
    .colors_checked  (colors_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the output side at random, except in steady stretches
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) begin
        stall_left <= gap_length();
      end
    end
  end

  // Present one word, hold it until accepted, then idle for a random gap
  task automatic drive_pixel(logic signed [15:0] hue, logic [7:0] sat, logic [7:0] val);
    int gap;
    in_valid       <= 1'b1;
    in_hue_degrees <= hue;
    in_saturation  <= sat;
    in_brightness  <= val;
    do @(posedge clk); while (!in_ready);
    words_sent = words_sent + 1;
    @(negedge clk);
    gap = steady ? 0 : gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Level with extra weight on the ends of the range
  function automatic logic [7:0] pick_level();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 8'd0;
    if (roll < 16) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  // Hue from the folded range, the full word, negatives or a sector edge
  function automatic logic signed [15:0] pick_hue();
    int roll;
    int edge_hue;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 16'($urandom_range(0, 359));
    if (roll < 70) return 16'($urandom_range(0, 65535));
    if (roll < 85) return -16'($urandom_range(1, 720));
    edge_hue = 60 * $urandom_range(0, 12) + $urandom_range(0, 2) - 1;
    return ($urandom_range(0, 1) == 1) ? 16'(edge_hue) : -16'(edge_hue);
  endfunction

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: fold corners, sector edges, level extremes
    drive_pixel(16'sd0,      8'd255, 8'd255);
    drive_pixel(16'sd59,     8'd255, 8'd255);
    drive_pixel(16'sd60,     8'd255, 8'd255);
    drive_pixel(16'sd120,    8'd255, 8'd255);
    drive_pixel(16'sd180,    8'd200, 8'd255);
    drive_pixel(16'sd240,    8'd255, 8'd128);
    drive_pixel(16'sd300,    8'd170, 8'd255);
    drive_pixel(16'sd359,    8'd255, 8'd255);
    drive_pixel(16'sd360,    8'd255, 8'd255);
    drive_pixel(16'sd720,    8'd100, 8'd200);
    drive_pixel(-16'sd30,    8'd255, 8'd255);
    drive_pixel(-16'sd360,   8'd255, 8'd255);
    drive_pixel(-16'sd1,     8'd255, 8'd255);
    drive_pixel(-16'sd32768, 8'd255, 8'd255);
    drive_pixel(16'sd32767,  8'd255, 8'd255);
    drive_pixel(16'sd90,     8'd0,   8'd255);
    drive_pixel(16'sd90,     8'd255, 8'd0);
    drive_pixel(16'sd200,    8'd0,   8'd0);
    drive_pixel(16'sd30,     8'd1,   8'd1);
    drive_pixel(16'sd150,    8'd128, 8'd127);
    drive_pixel(16'sd270,    8'd85,  8'd170);
    drive_pixel(16'sd330,    8'd254, 8'd254);

    // Random words, with a steady stretch and one full drain
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      steady = (n >= 200 && n < 300);
      if (n == 400) begin
        in_valid <= 1'b0;
        while (colors_pending != 0) @(negedge clk);
      end
      drive_pixel(pick_hue(), pick_level(), pick_level());
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Drain, then allow the pipe depth to settle
    while (colors_pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);

    $display("tb: %0d pixel words sent, %0d colors compared, %0d mismatches",
             words_sent, colors_checked, fail_count);
    $display("tb: covered hue fold corners, all six sectors and edges, zero and full levels");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
